// ===== sv/lpfe_pkg.sv =====
// Shared types and constants for the length-prefix frame encoder.
// Used by the front end, the job queue, the serializer and the top level.
package lpfe_pkg;

  localparam int unsigned LEN_W        = 64;
  localparam int unsigned BYTE_W       = 8;
  localparam logic [7:0]  SHORT_LIMIT  = 8'd255;
  localparam logic [7:0]  ESCAPE_BYTE  = 8'hff;
  localparam int unsigned LONG_HDR_LEN = 9;
  localparam int unsigned IDX_W        = 4;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = $clog2(QDEPTH);
  localparam int unsigned QCW    = $clog2(QDEPTH + 1);

  // One unit of work for the serializer: an optional size header followed
  // by an optional body byte.
  typedef struct packed {
    logic              hdr;
    logic              long_hdr;
    logic [LEN_W-1:0]  size;
    logic              err;
    logic              hend;
    logic              body_vld;
    logic [BYTE_W-1:0] body_byte;
    logic              body_fe;
  } lpfe_job_t;

endpackage

// ===== sv/length_prefix_frame_encoder.sv =====
// Length-prefix frame encoder. The front end takes one input item per cycle
// and classifies it into a job; a four-entry job queue feeds a serializer
// that sends one byte per cycle, unless out_stall holds it, through a
// registered output stage. An item yields 0 to 10 output bytes: a body byte
// one, a message start 1 or 2 (short header) or 9 or 10 (long header). Input
// is taken every cycle while the queue has room, so body streams run at one
// item per cycle; header bursts or out_stall can fill the queue and stall input.
// Depends on lpfe_pkg, lpfe_front, lpfe_queue and lpfe_back.
module length_prefix_frame_encoder (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic                        cfg_trim_mode,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [lpfe_pkg::BYTE_W-1:0] in_byte_value,
  input  logic                        in_starts_message,
  input  logic [lpfe_pkg::LEN_W-1:0]  in_message_length,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [lpfe_pkg::BYTE_W-1:0] out_out_byte,
  output logic                        out_run_last,
  output logic                        out_frame_end,
  output logic                        out_prefix_error
);

  logic                q_full;
  logic                push;
  lpfe_pkg::lpfe_job_t push_job;
  logic                head_vld;
  lpfe_pkg::lpfe_job_t head_job;
  logic                pop;
  logic                accept;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;
  assign accept    = in_valid && !q_full;

  lpfe_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid && cfg_ready),
    .cfg_trim_mode  (cfg_trim_mode),
    .accept         (accept),
    .byte_value     (in_byte_value),
    .starts_message (in_starts_message),
    .message_length (in_message_length),
    .push           (push),
    .job            (push_job)
  );

  lpfe_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .head_vld (head_vld),
    .head_job (head_job),
    .pop      (pop)
  );

  lpfe_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head_vld         (head_vld),
    .head_job         (head_job),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_byte         (out_out_byte),
    .out_run_last     (out_run_last),
    .out_frame_end    (out_frame_end),
    .out_prefix_error (out_prefix_error)
  );

endmodule

// ===== sv/lpfe_front.sv =====
// Front end: tracks the open message and turns accepted items into serializer
// jobs (none for trimmed or out-of-message bytes). Depends on lpfe_pkg.
module lpfe_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_valid,
  input  logic                        cfg_trim_mode,
  input  logic                        accept,
  input  logic [lpfe_pkg::BYTE_W-1:0] byte_value,
  input  logic                        starts_message,
  input  logic [lpfe_pkg::LEN_W-1:0]  message_length,
  output logic                        push,
  output lpfe_pkg::lpfe_job_t         job
);

  logic                        trim_r;
  logic                        in_msg_r, in_msg_nxt;
  logic [lpfe_pkg::LEN_W-1:0]  rem_r, rem_nxt;
  logic [lpfe_pkg::BYTE_W-1:0] skip_r, skip_nxt;

  logic [lpfe_pkg::BYTE_W-1:0] prefix;
  logic [lpfe_pkg::LEN_W:0]    diff;
  logic [lpfe_pkg::LEN_W-1:0]  size;
  logic                        err;
  logic                        len_zero;

  always_comb begin
    len_zero = (message_length == '0);
    prefix   = (trim_r && !len_zero) ? byte_value : '0;
    // The borrow out of the subtraction flags a trim count above the length.
    diff     = {1'b0, message_length} - {{(lpfe_pkg::LEN_W-lpfe_pkg::BYTE_W+1){1'b0}}, prefix};
    err      = diff[lpfe_pkg::LEN_W];
    size     = err ? '0 : diff[lpfe_pkg::LEN_W-1:0];
  end

  always_comb begin
    in_msg_nxt = in_msg_r;
    rem_nxt    = rem_r;
    skip_nxt   = skip_r;
    push       = 1'b0;
    job        = '0;
    job.body_byte = byte_value;
    if (accept) begin
      if (starts_message) begin
        push          = 1'b1;
        job.hdr       = 1'b1;
        job.long_hdr  = (size >= {{(lpfe_pkg::LEN_W-lpfe_pkg::BYTE_W){1'b0}},
                                  lpfe_pkg::SHORT_LIMIT});
        job.size      = size;
        job.err       = err;
        job.hend      = (size == '0);
        job.body_vld  = !len_zero && (prefix == '0);
        job.body_fe   = (message_length == lpfe_pkg::LEN_W'(1));
        in_msg_nxt    = !len_zero && !job.body_fe;
        rem_nxt       = message_length - lpfe_pkg::LEN_W'(1);
        skip_nxt      = (prefix == '0) ? '0 : prefix - lpfe_pkg::BYTE_W'(1);
      end else if (in_msg_r) begin
        job.body_vld = (skip_r == '0);
        job.body_fe  = (rem_r == lpfe_pkg::LEN_W'(1));
        push         = job.body_vld;
        rem_nxt      = rem_r - lpfe_pkg::LEN_W'(1);
        if (job.body_fe) begin
          in_msg_nxt = 1'b0;
        end
        if (skip_r != '0) begin
          skip_nxt = skip_r - lpfe_pkg::BYTE_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trim_r   <= 1'b0;
      in_msg_r <= 1'b0;
      rem_r    <= '0;
      skip_r   <= '0;
    end else begin
      if (cfg_valid) begin
        trim_r <= cfg_trim_mode;
      end
      in_msg_r <= in_msg_nxt;
      rem_r    <= rem_nxt;
      skip_r   <= skip_nxt;
    end
  end

  // A size of zero never has a body byte after its header.
  a_hend_no_body: assert property (@(posedge clk) disable iff (!rst_n)
    push && job.hdr && job.hend |-> !job.body_vld)
    else $error("empty frame header followed by a body byte");

  // An error header always reports size zero.
  a_err_size: assert property (@(posedge clk) disable iff (!rst_n)
    push && job.err |-> job.hdr && job.hend)
    else $error("trim error without a zero-size header");

  // A message that is still open has at least one byte left to count.
  a_rem_open: assert property (@(posedge clk) disable iff (!rst_n)
    in_msg_r |-> rem_r != '0)
    else $error("open message with no bytes remaining");

endmodule

// ===== sv/lpfe_queue.sv =====
// Short job queue between the front end and the serializer.
// Depends on lpfe_pkg for the job type and depth.
module lpfe_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  lpfe_pkg::lpfe_job_t push_job,
  output logic                full,
  output logic                head_vld,
  output lpfe_pkg::lpfe_job_t head_job,
  input  logic                pop
);

  lpfe_pkg::lpfe_job_t              mem_r [lpfe_pkg::QDEPTH];
  logic [lpfe_pkg::QAW-1:0]         wptr_r, wptr_nxt;
  logic [lpfe_pkg::QAW-1:0]         rptr_r, rptr_nxt;
  logic [lpfe_pkg::QCW-1:0]         cnt_r, cnt_nxt;
  logic                             do_push;
  logic                             do_pop;

  always_comb begin
    full     = (cnt_r == lpfe_pkg::QCW'(lpfe_pkg::QDEPTH));
    head_vld = (cnt_r != '0);
    head_job = mem_r[rptr_r];
    do_push  = push && !full;
    do_pop   = pop && head_vld;
    wptr_nxt = do_push ? wptr_r + lpfe_pkg::QAW'(1) : wptr_r;
    rptr_nxt = do_pop  ? rptr_r + lpfe_pkg::QAW'(1) : rptr_r;
    cnt_nxt  = cnt_r + lpfe_pkg::QCW'(do_push) - lpfe_pkg::QCW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= lpfe_pkg::QCW'(lpfe_pkg::QDEPTH))
    else $error("queue count above depth");

  a_no_lost_push: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("job pushed into a full queue");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) |-> (wptr_r == rptr_r))
    else $error("empty queue with unequal pointers");

endmodule

// ===== sv/lpfe_back.sv =====
// Serializer: walks the job at the queue head one output byte per cycle,
// while out_stall allows, into a registered output stage. Depends on lpfe_pkg.
module lpfe_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        head_vld,
  input  lpfe_pkg::lpfe_job_t         head_job,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [lpfe_pkg::BYTE_W-1:0] out_byte,
  output logic                        out_run_last,
  output logic                        out_frame_end,
  output logic                        out_prefix_error
);

  logic [lpfe_pkg::IDX_W-1:0]  idx_r, idx_nxt;
  logic                        vld_r, vld_nxt;
  logic [lpfe_pkg::BYTE_W-1:0] byte_r;
  logic                        last_r, fe_r, err_r;

  logic [lpfe_pkg::IDX_W-1:0]  hdr_cnt;
  logic [lpfe_pkg::IDX_W-1:0]  lsel;
  logic                        in_hdr;
  logic                        hdr_last;
  logic                        job_last;
  logic [lpfe_pkg::BYTE_W-1:0] cur_byte;
  logic                        cur_fe;
  logic                        cur_err;
  logic                        load;
  logic                        slot_free;

  always_comb begin
    hdr_cnt  = head_job.hdr ? (head_job.long_hdr ? lpfe_pkg::IDX_W'(lpfe_pkg::LONG_HDR_LEN)
                                                 : lpfe_pkg::IDX_W'(1))
                            : '0;
    in_hdr   = (idx_r < hdr_cnt);
    hdr_last = (idx_r == hdr_cnt - lpfe_pkg::IDX_W'(1));
    // Long header: escape byte, then the size most significant byte first.
    lsel     = lpfe_pkg::IDX_W'(lpfe_pkg::LONG_HDR_LEN - 1) - idx_r;
    if (in_hdr) begin
      if (!head_job.long_hdr) begin
        cur_byte = head_job.size[lpfe_pkg::BYTE_W-1:0];
      end else if (idx_r == '0) begin
        cur_byte = lpfe_pkg::ESCAPE_BYTE;
      end else begin
        cur_byte = head_job.size[{lsel[2:0], 3'b000} +: lpfe_pkg::BYTE_W];
      end
      cur_fe   = hdr_last && head_job.hend;
      cur_err  = head_job.err;
      job_last = hdr_last && !head_job.body_vld;
    end else begin
      cur_byte = head_job.body_byte;
      cur_fe   = head_job.body_fe;
      cur_err  = 1'b0;
      job_last = 1'b1;
    end
    slot_free = !vld_r || !out_stall;
    load      = head_vld && slot_free;
    pop       = load && job_last;
    idx_nxt   = load ? (job_last ? '0 : idx_r + lpfe_pkg::IDX_W'(1)) : idx_r;
    vld_nxt   = slot_free ? head_vld : vld_r;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= cur_byte;
      last_r <= job_last;
      fe_r   <= cur_fe;
      err_r  <= cur_err;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      vld_r <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      vld_r <= vld_nxt;
    end
  end

  assign out_valid        = vld_r;
  assign out_byte         = byte_r;
  assign out_run_last     = last_r;
  assign out_frame_end    = fe_r;
  assign out_prefix_error = err_r;

  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= lpfe_pkg::IDX_W'(lpfe_pkg::LONG_HDR_LEN))
    else $error("serializer index past the longest job");

  a_mid_job_head: assert property (@(posedge clk) disable iff (!rst_n)
    (idx_r != '0) |-> head_vld)
    else $error("job left the queue before all its bytes were sent");

  a_fe_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r && fe_r |-> last_r)
    else $error("frame end on a byte that is not the last of its item");

endmodule
